>>> rtl/core/dvc_pkg.sv
// Package for the duplicate vector counter: word types of the input and result
// channels, and the command and status groups between controller and datapath.
// No dependencies.
package dvc_pkg;

  localparam int IN_WORD_W = 32;
  localparam int CFG_W     = 8;
  localparam int INDEX_W   = 5;
  localparam int COUNT_W   = 6;

  typedef struct packed {
    logic [IN_WORD_W-1:0] element_word;
    logic                 last_of_set;
  } dvc_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] first_index;
    logic [COUNT_W-1:0] occurrence_count;
    logic [COUNT_W-1:0] distinct_total;
    logic               overflow;
    logic               last_result;
  } dvc_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic i_inc;
    logic grp_start;
    logic j_inc;
    logic grp_close;
    logic w_clear;
    logic rd_issue;
    logic word_next;
    logic vec_match;
    logic e_inc;
    logic gc_rd;
    logic out_fire;
    logic out_empty;
    logic clear_set;
  } dvc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic set_empty;
    logic i_end;
    logic seen_i;
    logic j_end;
    logic seen_j;
    logic words_eq;
    logic w_last;
    logic seen_e;
    logic k_last;
  } dvc_sts_t;

endpackage

>>> rtl/core/dvc_ctrl.sv
// Controller of the duplicate vector counter: load, pairwise compare and
// result sequencing. Depends on dvc_pkg for the command and status groups.
module dvc_ctrl
  import dvc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     last_of_set,
  input  dvc_sts_t sts,
  output dvc_cmd_t cmd,
  output logic     busy
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_CHECK     = 3'd1;
  localparam logic [2:0] S_SCAN_I    = 3'd2;
  localparam logic [2:0] S_SCAN_J    = 3'd3;
  localparam logic [2:0] S_READ      = 3'd4;
  localparam logic [2:0] S_CMP       = 3'd5;
  localparam logic [2:0] S_EMIT_SCAN = 3'd6;
  localparam logic [2:0] S_EMIT_OUT  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_of_set) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts.set_empty) begin
          cmd.out_empty = 1'b1;
          cmd.clear_set = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_SCAN_I;
        end
      end
      S_SCAN_I: begin
        if (sts.i_end) begin
          state_nxt = S_EMIT_SCAN;
        end else if (sts.seen_i) begin
          cmd.i_inc = 1'b1;
        end else begin
          cmd.grp_start = 1'b1;
          state_nxt     = S_SCAN_J;
        end
      end
      S_SCAN_J: begin
        if (sts.j_end) begin
          cmd.grp_close = 1'b1;
          state_nxt     = S_SCAN_I;
        end else if (sts.seen_j) begin
          cmd.j_inc = 1'b1;
        end else begin
          cmd.w_clear = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        // A mismatch ends this pair early; a full match marks the later vector.
        if (!sts.words_eq) begin
          cmd.j_inc = 1'b1;
          state_nxt = S_SCAN_J;
        end else if (sts.w_last) begin
          cmd.vec_match = 1'b1;
          state_nxt     = S_SCAN_J;
        end else begin
          cmd.word_next = 1'b1;
          state_nxt     = S_READ;
        end
      end
      S_EMIT_SCAN: begin
        if (sts.seen_e) begin
          cmd.e_inc = 1'b1;
        end else begin
          cmd.gc_rd = 1'b1;
          state_nxt = S_EMIT_OUT;
        end
      end
      S_EMIT_OUT: begin
        cmd.out_fire = 1'b1;
        if (sts.k_last) begin
          cmd.clear_set = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_EMIT_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  // The block only returns to idle on the edge that sends the final result.
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) && (state_nxt == S_IDLE) |-> (cmd.out_fire || cmd.out_empty))
    else $error("controller went idle without sending a final result");

endmodule

>>> rtl/core/dvc_datapath.sv
// Datapath of the duplicate vector counter: vector store, group count memory,
// seen marks, loop counters and the result register. Depends on dvc_pkg.
module dvc_datapath
  import dvc_pkg::*;
#(
  parameter int MAX_VECTORS = 32,
  parameter int MAX_WORDS   = 128,
  parameter int WORD_BITS   = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dvc_in_t          in_word,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  dvc_cmd_t         cmd,
  output dvc_sts_t         sts,
  output logic             out_strobe,
  output dvc_out_t         out_word
);

  localparam int VB  = $clog2(MAX_VECTORS);
  localparam int CW  = $clog2(MAX_VECTORS + 1);
  localparam int WB  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int LW  = $clog2(MAX_WORDS + 1);
  localparam int CFW = (LW > CFG_W) ? LW : CFG_W;
  localparam int AW  = VB + WB;

  logic [WORD_BITS-1:0] store [2**AW];
  logic [CW-1:0]        gc_mem [MAX_VECTORS];

  logic [LW-1:0]          len_r;
  logic [WB-1:0]          pos_r, pos_nxt;
  logic [CW-1:0]          vcnt_r, vcnt_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [MAX_VECTORS-1:0] seen_r, seen_nxt;
  logic [CW-1:0]          i_r, i_nxt;
  logic [CW-1:0]          j_r, j_nxt;
  logic [WB-1:0]          w_r, w_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [CW-1:0]          distinct_r, distinct_nxt;
  logic [CW-1:0]          e_r, e_nxt;
  logic [CW-1:0]          k_r, k_nxt;
  logic [WORD_BITS-1:0]   rda_r, rdb_r;
  logic [CW-1:0]          gc_rd_r;
  logic                   out_valid_r;
  dvc_out_t               out_word_r;

  logic [CFW-1:0] cfg_ext;
  logic [LW-1:0]  len_cfg;
  logic           vcnt_full;
  logic           pos_last;

  // Lengths of zero act as one; lengths beyond the store's row act as the row.
  assign cfg_ext = CFW'(cfg_wdata);
  always_comb begin
    priority if (cfg_ext == '0) begin
      len_cfg = LW'(1);
    end else if (cfg_ext > CFW'(MAX_WORDS)) begin
      len_cfg = LW'(MAX_WORDS);
    end else begin
      len_cfg = cfg_ext[LW-1:0];
    end
  end

  assign vcnt_full = (vcnt_r == CW'(MAX_VECTORS));
  assign pos_last  = (({1'b0, LW'(pos_r)} + 1'b1) == {1'b0, len_r});

  assign sts.set_empty = (vcnt_r == '0);
  assign sts.i_end     = (i_r == vcnt_r);
  assign sts.seen_i    = seen_r[i_r[VB-1:0]];
  assign sts.j_end     = (j_r == vcnt_r);
  assign sts.seen_j    = seen_r[j_r[VB-1:0]];
  assign sts.words_eq  = (rda_r == rdb_r);
  assign sts.w_last    = (({1'b0, LW'(w_r)} + 1'b1) == {1'b0, len_r});
  assign sts.seen_e    = seen_r[e_r[VB-1:0]];
  assign sts.k_last    = ((k_r + 1'b1) == distinct_r);

  always_comb begin
    pos_nxt      = pos_r;
    vcnt_nxt     = vcnt_r;
    ovf_nxt      = ovf_r;
    seen_nxt     = seen_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    w_nxt        = w_r;
    cnt_nxt      = cnt_r;
    distinct_nxt = distinct_r;
    e_nxt        = e_r;
    k_nxt        = k_r;

    if (cmd.load) begin
      if (vcnt_full) begin
        ovf_nxt = 1'b1;
      end else if (pos_last) begin
        pos_nxt  = '0;
        vcnt_nxt = vcnt_r + 1'b1;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
    if (cmd.i_inc) begin
      i_nxt = i_r + 1'b1;
    end
    if (cmd.grp_start) begin
      cnt_nxt = CW'(1);
      j_nxt   = i_r + 1'b1;
    end
    if (cmd.j_inc) begin
      j_nxt = j_r + 1'b1;
    end
    if (cmd.grp_close) begin
      distinct_nxt = distinct_r + 1'b1;
      i_nxt        = i_r + 1'b1;
    end
    if (cmd.w_clear) begin
      w_nxt = '0;
    end
    if (cmd.word_next) begin
      w_nxt = w_r + 1'b1;
    end
    if (cmd.vec_match) begin
      seen_nxt[j_r[VB-1:0]] = 1'b1;
      cnt_nxt               = cnt_r + 1'b1;
      j_nxt                 = j_r + 1'b1;
    end
    if (cmd.e_inc) begin
      e_nxt = e_r + 1'b1;
    end
    if (cmd.out_fire) begin
      e_nxt = e_r + 1'b1;
      k_nxt = k_r + 1'b1;
    end
    // Closing a set or a length change starts a fresh set.
    if (cmd.clear_set || cfg_we) begin
      pos_nxt      = '0;
      vcnt_nxt     = '0;
      ovf_nxt      = 1'b0;
      seen_nxt     = '0;
      i_nxt        = '0;
      j_nxt        = '0;
      w_nxt        = '0;
      cnt_nxt      = '0;
      distinct_nxt = '0;
      e_nxt        = '0;
      k_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= LW'(1);
      pos_r       <= '0;
      vcnt_r      <= '0;
      ovf_r       <= 1'b0;
      seen_r      <= '0;
      i_r         <= '0;
      j_r         <= '0;
      w_r         <= '0;
      cnt_r       <= '0;
      distinct_r  <= '0;
      e_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        len_r <= len_cfg;
      end
      pos_r       <= pos_nxt;
      vcnt_r      <= vcnt_nxt;
      ovf_r       <= ovf_nxt;
      seen_r      <= seen_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      w_r         <= w_nxt;
      cnt_r       <= cnt_nxt;
      distinct_r  <= distinct_nxt;
      e_r         <= e_nxt;
      k_r         <= k_nxt;
      out_valid_r <= cmd.out_fire || cmd.out_empty;
    end
  end

  // Vector store: one write port for loading, two read ports for compares.
  always_ff @(posedge clk) begin
    if (cmd.load && !vcnt_full) begin
      store[{vcnt_r[VB-1:0], pos_r}] <= WORD_BITS'(in_word.element_word);
    end
    if (cmd.rd_issue) begin
      rda_r <= store[{i_r[VB-1:0], w_r}];
      rdb_r <= store[{j_r[VB-1:0], w_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grp_close) begin
      gc_mem[i_r[VB-1:0]] <= cnt_r;
    end
    if (cmd.gc_rd) begin
      gc_rd_r <= gc_mem[e_r[VB-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_empty) begin
      out_word_r.first_index      <= '0;
      out_word_r.occurrence_count <= '0;
      out_word_r.distinct_total   <= '0;
      out_word_r.overflow         <= ovf_r;
      out_word_r.last_result      <= 1'b1;
    end else if (cmd.out_fire) begin
      out_word_r.first_index      <= INDEX_W'(e_r);
      out_word_r.occurrence_count <= COUNT_W'(gc_rd_r);
      out_word_r.distinct_total   <= COUNT_W'(distinct_r);
      out_word_r.overflow         <= ovf_r;
      out_word_r.last_result      <= sts.k_last;
    end
  end

  assign out_strobe = out_valid_r;
  assign out_word   = out_word_r;

  a_match_later: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.vec_match |-> (j_r > i_r))
    else $error("duplicate marked on a vector not after its group head");

  a_distinct_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.grp_close |-> (distinct_r < vcnt_r))
    else $error("more distinct groups than stored vectors");

  a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.last_result |-> (vcnt_r == '0) && (pos_r == '0))
    else $error("set state not cleared with the final result");

endmodule

>>> rtl/core/duplicate_vector_counter.sv
// Duplicate vector counter: collects equal-length vectors one word at a time
// and reports each distinct vector with its count.
//
// Input channel: a word is taken at a rising edge with start high and busy
// low. Words fill vector 0, then vector 1 and so on, cfg_wdata words each
// (zero counts as one, above MAX_WORDS as MAX_WORDS). The word with
// last_of_set high closes the set; busy then rises while the stored vectors
// are compared and the results go out.
// Result channel: one word per distinct vector, in order of first index, shown
// for one cycle with out_strobe high; the final one has last_result set. The
// receiver cannot stall. A set with no complete vector gives one result with
// zero counts.
// After the closing word, the compare walks vector pairs, reading one word of
// each at a time on the store's two read ports and ending a pair at its first
// mismatch. The user must write configuration only while busy is low; the
// block itself does not enforce it. A write also discards a partly loaded
// set. Reset clears all set state and the length becomes one word; the store
// keeps no reset value.
module duplicate_vector_counter
  import dvc_pkg::*;
#(
  parameter int MAX_VECTORS = 32,
  parameter int MAX_WORDS   = 128,
  parameter int WORD_BITS   = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  dvc_in_t          in_word,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output logic             out_strobe,
  output dvc_out_t         out_word
);

  dvc_cmd_t cmd;
  dvc_sts_t sts;

  dvc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .last_of_set (in_word.last_of_set),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy)
  );

  dvc_datapath #(
    .MAX_VECTORS (MAX_VECTORS),
    .MAX_WORDS   (MAX_WORDS),
    .WORD_BITS   (WORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule
